// ===== hw/rtl/tsgs_pkg.sv =====
`timescale 1ns / 1ps

package tsgs_pkg;

  // operation codes carried on s_axis_tuser
  typedef logic [1:0] op_t;
  localparam op_t OP_TICK = 2'd0;
  localparam op_t OP_GOTO = 2'd1;
  localparam op_t OP_SCAN = 2'd2;

  // task mode codes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_NONE = 2'd0;
  localparam mode_t MODE_GOTO = 2'd1;
  localparam mode_t MODE_SCAN = 2'd2;

  // widths of the stream payloads
  localparam int TARGET_BITS = 8;
  localparam int IN_DATA_BITS = 16;
  localparam int OUT_DATA_BITS = 24;

  // result layout, first member sits in the highest bits
  typedef struct packed {
    logic                   pad;
    mode_t                  mode;
    logic                   active;
    logic [TARGET_BITS-1:0] pos_b;
    logic [TARGET_BITS-1:0] pos_a;
    logic                   dir_b;
    logic                   dir_a;
    logic                   step_b;
    logic                   step_a;
  } result_t;

endpackage

// ===== hw/rtl/two_axis_stepper_goto_sweep.sv =====
`timescale 1ns / 1ps

// Two-axis stepper position sequencer. A goto or scan command (on s_axis_tuser)
// loads signed 8-bit targets for both axes and latches each axis direction;
// every tick then issues a step pulse on each axis away from its target and
// moves it one step toward it when that agrees with the latched direction.
// A finished goto turns into a scan to the negated first target. Each
// transfer in gives exactly one result transfer out, valid in the next cycle, and a
// new item is taken every cycle: all work is one level of compare and
// increment logic between the state registers and the output register, and
// input is held off only while that output register is full and stalled.
// POS_BITS sets the width of the internal position counters; positions are
// reported sign-extended or truncated to 8 bits.
module two_axis_stepper_goto_sweep #(
  parameter int POS_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // target_a [7:0], target_b [15:8]
  input  logic [tsgs_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // operation [1:0]
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // step_a [0], step_b [1], dir_a [2], dir_b [3], pos_a [11:4], pos_b [19:12],
  // active [20], mode [22:21], zero [23]
  output logic [tsgs_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);

  import tsgs_pkg::*;

  // state
  logic signed [POS_BITS-1:0] position_a, position_b;
  logic signed [POS_BITS-1:0] goal_a, goal_b;
  logic                       heading_a, heading_b;
  mode_t                      task_mode;

  logic signed [POS_BITS-1:0] position_a_next, position_b_next;
  logic signed [POS_BITS-1:0] goal_a_next, goal_b_next;
  logic                       heading_a_next, heading_b_next;
  mode_t                      task_mode_next;

  result_t result, result_next;
  logic    out_valid;
  logic    accept;
  op_t     op;

  logic [TARGET_BITS-1:0]          tgt_a_raw, tgt_b_raw;
  logic [POS_BITS+TARGET_BITS-1:0] tgt_a_ext, tgt_b_ext;
  logic signed [POS_BITS-1:0]      tgt_a, tgt_b;
  logic signed [POS_BITS-1:0]      adv_a, adv_b;
  logic signed [POS_BITS-1:0]      neg_goal_a;
  logic                            step_a, step_b;
  logic [POS_BITS+TARGET_BITS-1:0] rep_a_ext, rep_b_ext;

  // handshake: output register parts the two sides
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = result;
  assign op            = s_axis_tuser;

  // targets sign-extended from 8 bits and wrapped to the counter width
  assign tgt_a_raw = s_axis_tdata[TARGET_BITS-1:0];
  assign tgt_b_raw = s_axis_tdata[2*TARGET_BITS-1:TARGET_BITS];
  assign tgt_a_ext = {{POS_BITS{tgt_a_raw[TARGET_BITS-1]}}, tgt_a_raw};
  assign tgt_b_ext = {{POS_BITS{tgt_b_raw[TARGET_BITS-1]}}, tgt_b_raw};
  assign tgt_a     = tgt_a_ext[POS_BITS-1:0];
  assign tgt_b     = tgt_b_ext[POS_BITS-1:0];

  // one movement step per axis
  always_comb begin
    step_a = (position_a != goal_a);
    adv_a  = position_a;
    if (!heading_a && (position_a < goal_a)) begin
      adv_a = position_a + POS_BITS'(1);
    end else if (heading_a && (position_a > goal_a)) begin
      adv_a = position_a - POS_BITS'(1);
    end
    step_b = (position_b != goal_b);
    adv_b  = position_b;
    if (!heading_b && (position_b < goal_b)) begin
      adv_b = position_b + POS_BITS'(1);
    end else if (heading_b && (position_b > goal_b)) begin
      adv_b = position_b - POS_BITS'(1);
    end
  end

  assign neg_goal_a = POS_BITS'(0) - goal_a;

  // next state and result
  always_comb begin
    position_a_next = position_a;
    position_b_next = position_b;
    goal_a_next     = goal_a;
    goal_b_next     = goal_b;
    heading_a_next  = heading_a;
    heading_b_next  = heading_b;
    task_mode_next  = task_mode;
    result_next     = '0;
    case (op)
      OP_GOTO, OP_SCAN: begin
        goal_a_next        = tgt_a;
        goal_b_next        = tgt_b;
        heading_a_next     = (position_a > tgt_a);
        heading_b_next     = (position_b > tgt_b);
        task_mode_next     = (op == OP_GOTO) ? MODE_GOTO : MODE_SCAN;
        result_next.active = 1'b1;
      end
      OP_TICK: begin
        if (task_mode == MODE_GOTO || task_mode == MODE_SCAN) begin
          position_a_next    = adv_a;
          position_b_next    = adv_b;
          result_next.step_a = step_a;
          result_next.step_b = step_b;
          if (task_mode == MODE_GOTO) begin
            result_next.active = 1'b1;
            // goto done: sweep to the mirrored first target
            if (!step_a && !step_b) begin
              goal_a_next    = neg_goal_a;
              heading_a_next = (position_a > neg_goal_a);
              heading_b_next = (position_b > goal_b);
              task_mode_next = MODE_SCAN;
            end
          end else begin
            result_next.active = step_a || step_b;
          end
        end
      end
      default: begin
      end
    endcase
    result_next.dir_a = heading_a_next;
    result_next.dir_b = heading_b_next;
    result_next.pos_a = rep_a_ext[TARGET_BITS-1:0];
    result_next.pos_b = rep_b_ext[TARGET_BITS-1:0];
    result_next.mode  = task_mode_next;
  end

  // positions reported in 8 bits
  assign rep_a_ext = {{TARGET_BITS{position_a_next[POS_BITS-1]}}, position_a_next};
  assign rep_b_ext = {{TARGET_BITS{position_b_next[POS_BITS-1]}}, position_b_next};

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position_a <= '0;
      position_b <= '0;
      goal_a     <= '0;
      goal_b     <= '0;
      heading_a  <= 1'b0;
      heading_b  <= 1'b0;
      task_mode  <= MODE_NONE;
    end else if (accept) begin
      position_a <= position_a_next;
      position_b <= position_b_next;
      goal_a     <= goal_a_next;
      goal_b     <= goal_b_next;
      heading_a  <= heading_a_next;
      heading_b  <= heading_b_next;
      task_mode  <= task_mode_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  // every accepted item produces a result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  // a command transfer never steps and always reports active
  assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_GOTO || op == OP_SCAN)) |=>
      (!result.step_a && !result.step_b && result.active))
    else $error("command result shows a step or is inactive");

  // positions only change on an accepted tick
  assert property (@(posedge clk) disable iff (rst)
    !(accept && op == OP_TICK) |=> ($stable(position_a) && $stable(position_b)))
    else $error("position moved without a tick");

  // a step pulse only when that axis was away from its goal
  assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_TICK && position_a == goal_a) |=> !result.step_a)
    else $error("step pulse on axis a at its goal");
`endif

endmodule

// ===== bench/two_axis_stepper_goto_sweep_tb.sv =====
`timescale 1ns / 1ps

module two_axis_stepper_goto_sweep_tb;
  import tsgs_pkg::*;

  localparam op_t OP_IGNORED = 2'd3;
  localparam int RANDOM_ITEMS = 1450;
  localparam int STALL_AT_RESULT = 300;
  localparam int STALL_CYCLES = 60;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    op_t               op;
    logic signed [7:0] ta;
    logic signed [7:0] tb;
  } motion_cmd_t;

  // software copy of the sequencer state
  typedef struct {
    logic signed [7:0] pos_a;
    logic signed [7:0] pos_b;
    logic signed [7:0] goal_a;
    logic signed [7:0] goal_b;
    logic              head_a;
    logic              head_b;
    mode_t             cur_mode;
  } axes_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = OP_TICK;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  motion_cmd_t cmd_q[$];
  result_t     pending_results[$];
  axes_state_t plan_axes;
  axes_state_t live_axes;
  logic        plan_active;
  int          planned_items;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int          gap_left = 0;
  int          rx_wait = 0;
  int          hold_left = 0;
  logic        tx_burst = 1'b0;
  logic        rx_burst = 1'b0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          turnovers = 0;
  int          ignored_ops = 0;
  int          errors = 0;
  int          idle_cycles = 0;
  motion_cmd_t drive_cmd;

  two_axis_stepper_goto_sweep u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one step toward the goal, only when it agrees with the latched heading
  function automatic logic signed [7:0] nudge(input logic signed [7:0] p,
                                              input logic signed [7:0] g,
                                              input logic h);
    if (!h && p < g) return p + 8'sd1;
    if (h && p > g) return p - 8'sd1;
    return p;
  endfunction

  // load goals for both axes and latch headings from the current positions
  task automatic aim_axes(inout axes_state_t st, input logic signed [7:0] ga,
                          input logic signed [7:0] gb, input mode_t m);
    st.goal_a = ga;
    st.goal_b = gb;
    st.head_a = st.pos_a > st.goal_a;
    st.head_b = st.pos_b > st.goal_b;
    st.cur_mode = m;
  endtask

  // expected result of one command or tick, updates the state copy
  task automatic predict_motion(inout axes_state_t st, input op_t op,
                                input logic signed [7:0] ta,
                                input logic signed [7:0] tb,
                                output result_t res);
    logic pulse_a;
    logic pulse_b;
    res = '0;
    case (op)
      OP_GOTO: begin
        aim_axes(st, ta, tb, MODE_GOTO);
        res.active = 1'b1;
      end
      OP_SCAN: begin
        aim_axes(st, ta, tb, MODE_SCAN);
        res.active = 1'b1;
      end
      OP_TICK: begin
        if (st.cur_mode == MODE_GOTO || st.cur_mode == MODE_SCAN) begin
          pulse_a = st.pos_a != st.goal_a;
          pulse_b = st.pos_b != st.goal_b;
          st.pos_a = nudge(st.pos_a, st.goal_a, st.head_a);
          st.pos_b = nudge(st.pos_b, st.goal_b, st.head_b);
          res.step_a = pulse_a;
          res.step_b = pulse_b;
          if (st.cur_mode == MODE_GOTO) begin
            // finished goto turns into a scan to the mirrored first goal
            if (!pulse_a && !pulse_b) aim_axes(st, 8'sd0 - st.goal_a, st.goal_b, MODE_SCAN);
            res.active = 1'b1;
          end else begin
            res.active = pulse_a | pulse_b;
          end
        end
      end
      default: ;
    endcase
    res.dir_a = st.head_a;
    res.dir_b = st.head_b;
    res.pos_a = st.pos_a;
    res.pos_b = st.pos_b;
    res.mode = st.cur_mode;
  endtask

  // queue one item and track where the axes will be
  task automatic plan_item(input op_t op, input logic signed [7:0] ta,
                           input logic signed [7:0] tb);
    result_t r;
    motion_cmd_t c;
    c.op = op;
    c.ta = ta;
    c.tb = tb;
    cmd_q.push_back(c);
    predict_motion(plan_axes, op, ta, tb, r);
    plan_active = r.active;
    if (op != OP_IGNORED) planned_items++;
  endtask

  task automatic plan_tick();
    plan_item(OP_TICK, 8'($urandom), 8'($urandom));
  endtask

  // target near the current position or near zero, clamped to the range
  function automatic logic signed [7:0] near_target(input logic signed [7:0] p);
    int v;
    if ($urandom_range(0, 2) == 0) v = int'($urandom_range(0, 20)) - 10;
    else v = int'(p) + int'($urandom_range(0, 12)) - 6;
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return 8'(v);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // stimulus
  initial begin
    int pick;
    int cap;
    int n;
    op_t op;
    logic far;
    logic signed [7:0] ta;
    logic signed [7:0] tb;

    plan_axes = '{default: '0};
    planned_items = 0;

    // directed: idle tick, ignored op, short goto that turns into a scan
    plan_item(OP_TICK, 8'sh7f, -8'sd128);
    plan_item(OP_IGNORED, -8'sd128, 8'sh7f);
    plan_item(OP_GOTO, 8'sd2, -8'sd1);
    repeat (3) plan_tick();
    repeat (6) plan_tick();
    plan_item(OP_SCAN, 8'sd127, -8'sd128);
    repeat (2) plan_tick();
    plan_item(OP_IGNORED, 8'sh55, 8'shaa);
    plan_item(OP_GOTO, plan_axes.pos_a, plan_axes.pos_b);
    repeat (2) plan_tick();

    // full goto to the corner: the mirrored scan goal of -128 wraps to itself
    plan_item(OP_GOTO, -8'sd128, 8'sd127);
    while (plan_active) plan_tick();
    plan_tick();

    // random command sequences, mostly run to completion
    while (planned_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        plan_item(op_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      end else begin
        op = (pick < 70) ? OP_GOTO : OP_SCAN;
        far = ($urandom_range(0, 49) == 0);
        ta = far ? 8'($urandom) : near_target(plan_axes.pos_a);
        tb = far ? 8'($urandom) : near_target(plan_axes.pos_b);
        plan_item(op, ta, tb);
        cap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 600;
        n = 0;
        while (plan_active && n < cap) begin
          plan_tick();
          n++;
        end
        repeat ($urandom_range(0, 2)) plan_tick();
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (!(cmd_q.size() == 0 && !s_axis_tvalid && pending_results.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);

    $display("run: %0d items sent, %0d results checked, %0d ignored operations",
             items_sent, results_seen, ignored_ops);
    $display("run: %0d goto moves turned into scans, one long output stall", turnovers);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // sender: presents queued items with random gaps or in bursts
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (in_fire) gap_left = tx_burst ? 0 : $urandom_range(0, 3);
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        drive_cmd = cmd_q.pop_front();
        s_axis_tdata <= {drive_cmd.tb, drive_cmd.ta};
        s_axis_tuser <= drive_cmd.op;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
    end
  end

  // receiver: random stalls per result, plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (out_fire) begin
        rx_wait = rx_burst ? 0 : $urandom_range(0, 3);
        if (results_seen == STALL_AT_RESULT) hold_left = STALL_CYCLES;
        if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    result_t want;
    result_t got;
    op_t in_op;
    in_fire <= s_axis_tvalid && s_axis_tready;
    out_fire <= m_axis_tvalid && m_axis_tready;
    if (rst) begin
      live_axes = '{default: '0};
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_op = s_axis_tuser;
        if (in_op == OP_IGNORED) ignored_ops++;
        if (in_op == OP_TICK && live_axes.cur_mode == MODE_GOTO) begin
          predict_motion(live_axes, in_op, s_axis_tdata[7:0], s_axis_tdata[15:8], want);
          if (want.mode == MODE_SCAN) turnovers++;
        end else begin
          predict_motion(live_axes, in_op, s_axis_tdata[7:0], s_axis_tdata[15:8], want);
        end
        pending_results.push_back(want);
        items_sent++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata);
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: %h", m_axis_tdata);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("step_a", want.step_a, got.step_a);
          check_field("step_b", want.step_b, got.step_b);
          check_field("dir_a", want.dir_a, got.dir_a);
          check_field("dir_b", want.dir_b, got.dir_b);
          check_field("pos_a", $signed(want.pos_a), $signed(got.pos_a));
          check_field("pos_b", $signed(want.pos_b), $signed(got.pos_b));
          check_field("active", want.active, got.active);
          check_field("mode", want.mode, got.mode);
          check_field("pad", want.pad, got.pad);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/tsgs_pkg.sv
hw/rtl/two_axis_stepper_goto_sweep.sv
bench/two_axis_stepper_goto_sweep_tb.sv
